// ----- design/fmp_pkg.sv -----
// Shared command and status types for the Fibonacci-mod-m unit.
package fmp_pkg;

  // One-hot datapath commands issued by the controller.
  typedef struct packed {
    logic load;         // capture request, seed pair (0,1), count = 1
    logic search_step;  // advance pair, count++
    logic div_init;     // latch period, clear remainder
    logic div_step;     // one restoring-division bit
    logic fib_init;     // seed pair (0,1), count = remainder
    logic fib_step;     // advance pair, count--
    logic out_load;     // capture result
  } cmd_t;

  typedef struct packed {
    logic mod_small;    // modulus is 0 or 1
    logic period_found; // next pair is (0,1) or search bound reached
    logic div_last;     // final quotient bit this cycle
    logic fib_done;     // remaining step count <= 1
  } sts_t;

endpackage

// ----- design/fmp_ctrl.sv -----
// Controller state machine sequencing search, index reduction and final walk.
module fmp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  fmp_pkg::sts_t sts,
  output fmp_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_FINIT  = 3'd3;
  localparam logic [2:0] ST_FIB    = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts.mod_small) begin
          state_nxt = ST_DONE;
        end else if (sts.period_found) begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_FINIT;
      end
      ST_FINIT: begin
        cmd.fib_init = 1'b1;
        state_nxt    = ST_FIB;
      end
      ST_FIB: begin
        if (sts.fib_done) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.fib_step = 1'b1;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/fmp_dp.sv -----
// Datapath: Fibonacci pair mod m, step counter, bit-serial index divider.
module fmp_dp #(
  parameter int MOD_BITS   = 16,
  parameter int INDEX_BITS = 63
) (
  input  logic                  clk,
  input  logic [INDEX_BITS-1:0] index_n,
  input  logic [MOD_BITS-1:0]   modulus,
  input  fmp_pkg::cmd_t         cmd,
  output fmp_pkg::sts_t         sts,
  output logic [MOD_BITS-1:0]   fib_mod
);

  // period <= 6m needs three bits above the modulus
  localparam int PW = MOD_BITS + 3;
  localparam int BW = $clog2(INDEX_BITS);

  logic [MOD_BITS-1:0]   m_r;
  logic [MOD_BITS-1:0]   a_r, b_r;
  logic [PW-1:0]         cnt_r;
  logic [PW-1:0]         period_r;
  logic [PW-1:0]         rem_r;
  logic [INDEX_BITS-1:0] n_r;
  logic [BW-1:0]         bit_r;
  logic [MOD_BITS-1:0]   result_r;

  logic [MOD_BITS:0]     sum;
  logic [MOD_BITS-1:0]   nb;
  logic [PW-1:0]         limit;
  logic [PW:0]           shifted;
  logic [PW:0]           trial;
  logic [PW-1:0]         rem_nxt;

  // a, b < m so one conditional subtract reduces the sum
  assign sum   = {1'b0, a_r} + {1'b0, b_r};
  assign nb    = (sum >= {1'b0, m_r}) ? MOD_BITS'(sum - {1'b0, m_r}) : sum[MOD_BITS-1:0];
  assign limit = (PW'(m_r) << 2) + (PW'(m_r) << 1);

  assign shifted = {rem_r, n_r[INDEX_BITS-1]};
  assign trial   = shifted - {1'b0, period_r};
  assign rem_nxt = (shifted >= {1'b0, period_r}) ? trial[PW-1:0] : shifted[PW-1:0];

  assign sts.mod_small    = (m_r <= MOD_BITS'(1));
  assign sts.period_found = ((b_r == '0) && (nb == MOD_BITS'(1))) || (cnt_r == limit);
  assign sts.div_last     = (bit_r == BW'(INDEX_BITS - 1));
  assign sts.fib_done     = (cnt_r <= PW'(1));

  assign fib_mod = result_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r   <= index_n;
      m_r   <= modulus;
      a_r   <= '0;
      b_r   <= MOD_BITS'(1);
      cnt_r <= PW'(1);
    end
    if (cmd.search_step) begin
      a_r   <= b_r;
      b_r   <= nb;
      cnt_r <= cnt_r + PW'(1);
    end
    if (cmd.div_init) begin
      period_r <= cnt_r;
      rem_r    <= '0;
      bit_r    <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      n_r   <= n_r << 1;
      bit_r <= bit_r + BW'(1);
    end
    if (cmd.fib_init) begin
      a_r   <= '0;
      b_r   <= MOD_BITS'(1);
      cnt_r <= rem_r;
    end
    if (cmd.fib_step) begin
      a_r   <= b_r;
      b_r   <= nb;
      cnt_r <= cnt_r - PW'(1);
    end
    if (cmd.out_load) begin
      // reduced index 0 gives 0; index r >= 1 leaves F(r) in b
      result_r <= (sts.mod_small || (cnt_r == '0)) ? '0 : b_r;
    end
  end

endmodule

// ----- design/fibonacci_mod_pisano_unit.sv -----
// F(n) mod m: Pisano period search, n mod period, then a mod-m walk.
// Usage: one request at a time. P <= 6m is the Pisano period of m found by the search
// loop and r < P is n mod P, from which the final walk forms F(r) mod m; m of 0 or 1
// skips the search, division and walk and answers 0.
// Search and final walk share one mod-m adder; the index reduction is a restoring divider
// that retires one bit of n per cycle. A finished result sits in the output register, so
// the next request is taken while it waits to be read.
module fibonacci_mod_pisano_unit #(
  parameter int MOD_BITS   = 16,
  parameter int INDEX_BITS = 63
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_tvalid,
  output logic                                           in_tready,
  // [INDEX_BITS-1:0] index_n, [INDEX_BITS+MOD_BITS-1:INDEX_BITS] modulus, rest zero pad
  input  logic [((INDEX_BITS + MOD_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                                           out_tvalid,
  input  logic                                           out_tready,
  // [MOD_BITS-1:0] fib_mod, rest zero pad
  output logic [((MOD_BITS + 7) / 8) * 8 - 1:0]          out_tdata
);

  localparam int OUT_W = ((MOD_BITS + 7) / 8) * 8;

  fmp_pkg::cmd_t       cmd;
  fmp_pkg::sts_t       sts;
  logic [MOD_BITS-1:0] fib_mod;

  fmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fmp_dp #(
    .MOD_BITS   (MOD_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk     (clk),
    .index_n (in_tdata[INDEX_BITS-1:0]),
    .modulus (in_tdata[INDEX_BITS+MOD_BITS-1:INDEX_BITS]),
    .cmd     (cmd),
    .sts     (sts),
    .fib_mod (fib_mod)
  );

  assign out_tdata = OUT_W'(fib_mod);

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input still ready right after taking a request");

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.search_step, cmd.div_init, cmd.div_step,
              cmd.fib_init, cmd.fib_step, cmd.out_load}))
    else $error("more than one datapath command in a cycle");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("loaded result not presented");
`endif

endmodule
